>>> src/lpa_pkg.sv
// Shared widths, constants, types and the divisor reciprocal table for the air-time estimator.
`timescale 1ns / 1ps

package lpa_pkg;

    // Register map, word index of each register
    localparam logic [1:0] REG_SF  = 2'd0;
    localparam logic [1:0] REG_BW  = 2'd1;
    localparam logic [1:0] REG_CR  = 2'd2;
    localparam logic [1:0] REG_PRE = 2'd3;

    // Reset values of the registers
    localparam logic [3:0]  SF_RESET  = 4'd7;
    localparam logic [18:0] BW_RESET  = 19'd250000;
    localparam logic [3:0]  CR_RESET  = 4'd5;
    localparam logic [15:0] PRE_RESET = 16'd16;

    // Limits applied to the programmed values
    localparam logic [3:0]  SF_MIN     = 4'd6;
    localparam logic [3:0]  SF_MAX     = 4'd12;
    localparam logic [3:0]  CR_MIN     = 4'd5;
    localparam logic [18:0] BW_DEFAULT = 19'd250000;

    // Widths of the datapath
    localparam int NUM_W   = 39;            // dividend: total * 1000 * 2^(sf-2)
    localparam int DEN_W   = 19;            // divisor: bandwidth in Hz
    localparam int OUT_W   = 38;            // result field
    localparam int RCP_W   = 15;            // reciprocal of the symbol-count divisor
    localparam int RCP_SH  = 16;            // reciprocal scale, 2^16
    localparam int DIV_STEPS = NUM_W;       // one quotient bit per divider stage

    typedef struct packed {
        logic             valid;
        logic [NUM_W-1:0] dividend;
    } t_div_req;

    typedef struct packed {
        logic             valid;
        logic [NUM_W-1:0] quotient;
    } t_div_rsp;

    // ceil(2^16 / m) for the symbol divisor m = sf - 2*de, which lies in 4..12
    function automatic logic [RCP_W-1:0] sym_recip(input logic [3:0] m);
        logic [RCP_W-1:0] r;
        case (m)
            4'd4:    r = 15'd16384;
            4'd5:    r = 15'd13108;
            4'd6:    r = 15'd10923;
            4'd7:    r = 15'd9363;
            4'd8:    r = 15'd8192;
            4'd9:    r = 15'd7282;
            4'd10:   r = 15'd6554;
            4'd11:   r = 15'd5958;
            4'd12:   r = 15'd5462;
            default: r = 15'd16384;
        endcase
        return r;
    endfunction

endpackage

>>> src/lora_packet_airtime.sv
// Top level: LoRa packet air-time estimator with register port, pipeline and divider.
`timescale 1ns / 1ps
//
//  channel   direction  handshake                  payload
//  input     in         i_valid / o_stall          i_frame_len   [7:0]
//  output    out        o_valid / i_stall          o_airtime_ms  [37:0]
//  config    in         psel penable pwrite pready paddr [3:0], pwdata / prdata [31:0]
//
//  One request enters per cycle while the pipeline is not frozen; each result passes five
//  arithmetic stages, a 39-stage divider retiring one quotient bit per stage and one output
//  register. A one-entry skid register at the input keeps o_stall registered and takes one
//  more request while a result waits at the output; it enters once the freeze ends. i_stall
//  freezes the whole pipeline while o_valid is high; nothing is lost or repeated.
//  Synchronous reset empties the pipeline and restores the register defaults.

module lora_packet_airtime
    import lpa_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [7:0]          i_frame_len,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [OUT_W-1:0]    o_airtime_ms,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    // Configuration registers
    logic [3:0]  r_sf;
    logic [18:0] r_bw;
    logic [3:0]  r_cr;
    logic [15:0] r_pre;

    // Settings derived from the registers
    logic [3:0]       sf_c;
    logic [3:0]       cr_c;
    logic [DEN_W-1:0] bw_c;
    logic [23:0]      sym_scaled;
    logic [23:0]      bw_x16;
    logic             ldro;
    logic [3:0]       sym_m;
    logic [RCP_W-1:0] sym_rcp;

    // Skid register and pipeline control
    logic       r_skid_valid;
    logic [7:0] r_skid_len;
    logic       core_en;
    logic       core_valid;
    logic [7:0] core_len;

    // Arithmetic stages
    logic        r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid, r_s5_valid;
    logic        r_s1_pos;
    logic [23:0] r_s1_prod;
    logic [10:0] r_s2_nsym;
    logic [18:0] r_s3_total;
    logic [28:0] r_s4_scaled;
    logic [NUM_W-1:0] r_s5_dividend;

    logic [NUM_W-1:0] n_s5_dividend;
    logic [10:0]      sym_k;
    logic [9:0]       sym_a;
    logic [23:0]      n_s1_prod;
    logic [7:0]       sym_q;
    logic [11:0]      sym_qcr;
    logic [10:0]      n_s2_nsym;
    logic [18:0]      n_s3_total;
    logic [28:0]      n_s4_scaled;

    t_div_req div_req;
    t_div_rsp div_rsp;

    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data;
    logic [OUT_W:0]   n_out_sum;

    logic cfg_wr;

    // Register port: always ready, write on the access phase
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sf  <= SF_RESET;
            r_bw  <= BW_RESET;
            r_cr  <= CR_RESET;
            r_pre <= PRE_RESET;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_SF:  r_sf  <= pwdata[3:0];
                REG_BW:  r_bw  <= pwdata[18:0];
                REG_CR:  r_cr  <= pwdata[3:0];
                REG_PRE: r_pre <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_SF:  prdata = {28'd0, r_sf};
            REG_BW:  prdata = {13'd0, r_bw};
            REG_CR:  prdata = {28'd0, r_cr};
            REG_PRE: prdata = {16'd0, r_pre};
            default: prdata = '0;
        endcase
    end

    // Clamp the settings; decide low-data-rate optimization from symbol time above 16 ms
    always_comb begin
        if (r_sf < SF_MIN)      sf_c = SF_MIN;
        else if (r_sf > SF_MAX) sf_c = SF_MAX;
        else                    sf_c = r_sf;
        cr_c       = (r_cr < CR_MIN) ? CR_MIN : r_cr;
        bw_c       = (r_bw == '0) ? BW_DEFAULT : r_bw;
        sym_scaled = 24'd1000 << sf_c;
        bw_x16     = {1'b0, bw_c, 4'd0};
        ldro       = sym_scaled > bw_x16;
        sym_m      = ldro ? (sf_c - 4'd2) : sf_c;
        sym_rcp    = sym_recip(sym_m);
    end

    // Skid register: hold one request while the pipeline is frozen
    assign core_en    = !(r_out_valid && i_stall);
    assign core_valid = r_skid_valid || i_valid;
    assign core_len   = r_skid_valid ? r_skid_len : i_frame_len;
    assign o_stall    = r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else if (core_en) begin
            r_skid_valid <= 1'b0;
        end else if (!r_skid_valid && i_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!core_en && !r_skid_valid && i_valid) begin
            r_skid_len <= i_frame_len;
        end
    end

    // Stage 1: payload symbol numerator over 4, rounded up, times the reciprocal
    always_comb begin
        sym_k     = $signed({2'b00, core_len, 1'b0}) + 11'sd11 - $signed({7'd0, sf_c});
        sym_a     = sym_k[9:0] + {6'd0, sym_m} - 10'd1;
        n_s1_prod = 24'(sym_a * sym_rcp);
    end

    // Stage 2: symbol count, 8 plus coding-rate blocks when the numerator is positive
    always_comb begin
        sym_q     = r_s1_prod[RCP_SH +: 8];
        sym_qcr   = sym_q * cr_c;
        n_s2_nsym = r_s1_pos ? (11'd8 + sym_qcr[10:0]) : 11'd8;
    end

    // Stage 3: quarter-symbol count of the whole packet
    assign n_s3_total = {1'b0, r_pre, 2'b00} + 19'd17 + {6'd0, r_s2_nsym, 2'b00};

    // Stage 4: times 1000
    assign n_s4_scaled = 29'(r_s3_total * 10'd1000);

    // Stage 5: times 2^sf, with the quarter folded in as sf - 2
    assign n_s5_dividend = {10'd0, r_s4_scaled} << (sf_c - 4'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
        end else if (core_en) begin
            r_s1_valid <= core_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
            r_s5_valid <= r_s4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_en) begin
            r_s1_pos      <= !sym_k[10] && (sym_k != '0);
            r_s1_prod     <= n_s1_prod;
            r_s2_nsym     <= n_s2_nsym;
            r_s3_total    <= n_s3_total;
            r_s4_scaled   <= n_s4_scaled;
            r_s5_dividend <= n_s5_dividend;
        end
    end

    // Divide by the bandwidth
    assign div_req.valid    = r_s5_valid;
    assign div_req.dividend = r_s5_dividend;

    lpa_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (core_en),
        .i_req     (div_req),
        .i_divisor (bw_c),
        .o_rsp     (div_rsp)
    );

    // Output register: floor plus one, truncated to the field
    assign n_out_sum = div_rsp.quotient[OUT_W:0] + {{OUT_W{1'b0}}, 1'b1};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (core_en) begin
            r_out_valid <= div_rsp.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_en) begin
            r_out_data <= n_out_sum[OUT_W-1:0];
        end
    end

    assign o_valid      = r_out_valid;
    assign o_airtime_ms = r_out_data;

endmodule

>>> src/lpa_div.sv
// Pipelined restoring divider: one quotient bit per stage, one request per cycle while i_en is high.
`timescale 1ns / 1ps

module lpa_div
    import lpa_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  t_div_req         i_req,
    input  logic [DEN_W-1:0] i_divisor,
    output t_div_rsp         o_rsp
);

    logic             r_vld [DIV_STEPS];
    logic [DEN_W-1:0] r_rem [DIV_STEPS];
    logic [NUM_W-1:0] r_dq  [DIV_STEPS];

    logic             n_vld [DIV_STEPS];
    logic [DEN_W-1:0] n_rem [DIV_STEPS];
    logic [NUM_W-1:0] n_dq  [DIV_STEPS];

    // Each stage shifts in one dividend bit and subtracts the divisor when it fits
    always_comb begin
        logic             vin;
        logic [DEN_W-1:0] rin;
        logic [NUM_W-1:0] dqin;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        for (int s = 0; s < DIV_STEPS; s++) begin
            if (s == 0) begin
                vin  = i_req.valid;
                rin  = '0;
                dqin = i_req.dividend;
            end else begin
                vin  = r_vld[s-1];
                rin  = r_rem[s-1];
                dqin = r_dq[s-1];
            end
            trial = {rin, dqin[NUM_W-1]};
            diff  = trial - {1'b0, i_divisor};
            n_vld[s] = vin;
            if (trial >= {1'b0, i_divisor}) begin
                n_rem[s] = diff[DEN_W-1:0];
                n_dq[s]  = {dqin[NUM_W-2:0], 1'b1};
            end else begin
                n_rem[s] = trial[DEN_W-1:0];
                n_dq[s]  = {dqin[NUM_W-2:0], 1'b0};
            end
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DIV_STEPS; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (i_en) begin
            for (int s = 0; s < DIV_STEPS; s++) begin
                r_vld[s] <= n_vld[s];
            end
        end
    end

    // Advance partial remainders and quotient bits
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < DIV_STEPS; s++) begin
                r_rem[s] <= n_rem[s];
                r_dq[s]  <= n_dq[s];
            end
        end
    end

    assign o_rsp.valid    = r_vld[DIV_STEPS-1];
    assign o_rsp.quotient = r_dq[DIV_STEPS-1];

endmodule
